// File: hw/rtl/signed_int_to_decimal_ascii_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the signed integer to decimal text block
// Clocked property checks on clk_i with the low-active reset rst_ni.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH

`ifndef SYNTHESIS
// Check that a property holds at every clock edge out of reset
`define SITDA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check that a condition never occurs out of reset
`define SITDA_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define SITDA_ASSERT(name, prop, msg)
`define SITDA_NEVER(name, cond, msg)
`endif

`endif

// File: hw/rtl/sitda_pkg.sv
// ----------------------------------------------------------------------------
// Package for the signed integer to decimal text block
// Shared constants and the control bundle between converter and emitter.
// ----------------------------------------------------------------------------
package sitda_pkg;

  // Default width of the integer operand
  localparam int DefaultDataWidth = 32;

  // ASCII codes, 6 bits wide
  localparam logic [5:0] CharZero  = 6'd48;
  localparam logic [5:0] CharNine  = 6'd57;
  localparam logic [5:0] CharMinus = 6'd45;

  // Converter to emitter hand-off: BCD word ready, and the sign of the number
  typedef struct packed {
    logic load;
    logic neg;
  } sitda_ctl_t;

endpackage

// File: hw/rtl/sitda_dabble.sv
// ----------------------------------------------------------------------------
// Binary to BCD converter, bit serial
// Shift-and-add-3 over one magnitude bit per cycle, all DataWidth bits of a number.
// ----------------------------------------------------------------------------
module sitda_dabble #(
  parameter int DataWidth = sitda_pkg::DefaultDataWidth,
  parameter int NumDigits = 10
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic                     neg_i,
  input  logic [DataWidth-1:0]     mag_i,
  output logic                     busy_o,
  output sitda_pkg::sitda_ctl_t    ctl_o,
  output logic [NumDigits*4-1:0]   bcd_o
);

  localparam int CntW = $clog2(DataWidth + 1);
  localparam int BcdW = NumDigits * 4;

  typedef enum logic [1:0] {
    DabIdle = 2'b01,
    DabRun  = 2'b10
  } dab_state_e;

  dab_state_e           state_q, state_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 done_q, done_d;
  logic                 neg_q, neg_d;
  logic [DataWidth-1:0] bin_q, bin_d;
  logic [BcdW-1:0]      bcd_q, bcd_d;
  logic [BcdW-1:0]      bcd_adj;

  // Add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_q[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
      end
    end
  end

  // Sequence the shifts
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    neg_d   = neg_q;
    bin_d   = bin_q;
    bcd_d   = bcd_q;
    unique case (state_q)
      DabIdle: begin
        // Take a new transaction only once the finished word has been handed off
        if (start_i && !done_q) begin
          state_d = DabRun;
          cnt_d   = CntW'(DataWidth);
          neg_d   = neg_i;
          bin_d   = mag_i;
          bcd_d   = '0;
        end
      end
      DabRun: begin
        bcd_d = {bcd_adj[BcdW-2:0], bin_q[DataWidth-1]};
        bin_d = {bin_q[DataWidth-2:0], 1'b0};
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          state_d = DabIdle;
          done_d  = 1'b1;
        end
      end
      default: begin
        state_d = DabIdle;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DabIdle;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // Hold the working registers
  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign busy_o     = (state_q == DabRun) | done_q;
  assign ctl_o.load = done_q;
  assign ctl_o.neg  = neg_q;
  assign bcd_o      = bcd_q;

endmodule

// File: hw/rtl/sitda_emit.sv
// ----------------------------------------------------------------------------
// Character emitter
// Sends an optional minus sign, then the BCD digits top first, one per cycle,
// dropping leading zeros.
// ----------------------------------------------------------------------------
module sitda_emit #(
  parameter int NumDigits = 10
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sitda_pkg::sitda_ctl_t  ctl_i,
  input  logic [NumDigits*4-1:0] bcd_i,
  output logic                   busy_o,
  output logic                   strobe_o,
  output logic [5:0]             ascii_char_o,
  output logic                   last_o
);

  localparam int RemW = $clog2(NumDigits + 1);
  localparam int BcdW = NumDigits * 4;

  typedef enum logic [2:0] {
    EmIdle   = 3'b001,
    EmSign   = 3'b010,
    EmDigits = 3'b100
  } em_state_e;

  em_state_e        state_q, state_d;
  logic [RemW-1:0]  rem_q, rem_d;
  logic             seen_q, seen_d;
  logic [BcdW-1:0]  sh_q, sh_d;
  logic             strobe_q, strobe_d;
  logic             last_q, last_d;
  logic [5:0]       char_q, char_d;
  logic [3:0]       top_dig;

  assign top_dig = sh_q[BcdW-1 -: 4];

  // Step through sign and digits
  always_comb begin
    state_d  = state_q;
    rem_d    = rem_q;
    seen_d   = seen_q;
    sh_d     = sh_q;
    strobe_d = 1'b0;
    last_d   = 1'b0;
    char_d   = char_q;
    unique case (state_q)
      EmIdle: begin
        if (ctl_i.load) begin
          state_d = ctl_i.neg ? EmSign : EmDigits;
          rem_d   = RemW'(NumDigits);
          seen_d  = 1'b0;
          sh_d    = bcd_i;
        end
      end
      EmSign: begin
        strobe_d = 1'b1;
        char_d   = sitda_pkg::CharMinus;
        state_d  = EmDigits;
      end
      EmDigits: begin
        // Emit once a nonzero digit shows up, and always the units digit
        if (seen_q || (top_dig != 4'd0) || (rem_q == RemW'(1))) begin
          strobe_d = 1'b1;
          seen_d   = 1'b1;
          char_d   = sitda_pkg::CharZero + 6'(top_dig);
          last_d   = (rem_q == RemW'(1));
        end
        sh_d  = {sh_q[BcdW-5:0], 4'd0};
        rem_d = rem_q - RemW'(1);
        if (rem_q == RemW'(1)) begin
          state_d = EmIdle;
        end
      end
      default: begin
        state_d = EmIdle;
      end
    endcase
  end

  // Hold control state and the output strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= EmIdle;
      rem_q    <= '0;
      seen_q   <= 1'b0;
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      rem_q    <= rem_d;
      seen_q   <= seen_d;
      strobe_q <= strobe_d;
      last_q   <= last_d;
    end
  end

  // Hold the digit shift register and the character
  always_ff @(posedge clk_i) begin
    sh_q   <= sh_d;
    char_q <= char_d;
  end

  assign busy_o       = (state_q != EmIdle);
  assign strobe_o     = strobe_q;
  assign ascii_char_o = char_q;
  assign last_o       = last_q;

endmodule

// File: hw/rtl/signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII text
// Converts one two's-complement integer per transaction into its decimal text.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive value_i and raise start; the transaction is taken at a
//   clock edge where start is high and busy is low.
//   Output: each character appears on ascii_char_o for one cycle with
//   strobe_o high; last_o marks the final character of the number. A
//   negative number opens with '-', digits follow top first without
//   leading zeros, and zero gives a single '0'.
//   Conversion: the bit-serial BCD converter shifts in one magnitude bit per
//   cycle; the emitter then loads the finished BCD word and shows the sign
//   or the top digit slot first, one slot per cycle after that, with
//   leading zero slots left unstrobed.
//   Busy: busy stays high while the converter runs and while it hands the
//   finished word to the emitter, so a new number is taken only after
//   that hand-off; the converter loop sets the pace, and emission of one
//   number overlaps conversion of the next.
//   Reset: rst_ni clears all control state; nothing is emitted until the
//   first transaction. The receiver cannot stall: every strobe is taken.
// ----------------------------------------------------------------------------
`include "signed_int_to_decimal_ascii_defines.svh"

module signed_int_to_decimal_ascii #(
  parameter int DATA_WIDTH = sitda_pkg::DefaultDataWidth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] value_i,
  output logic                         strobe_o,
  output logic [5:0]                   ascii_char_o,
  output logic                         last_o
);

  // Decimal digits of 2^(DATA_WIDTH-1)
  localparam int NumDigits = ((DATA_WIDTH - 1) * 30103) / 100000 + 1;

  logic                      neg;
  logic [DATA_WIDTH-1:0]     mag;
  logic                      dab_busy;
  logic                      emit_busy;
  sitda_pkg::sitda_ctl_t     ctl;
  logic [NumDigits*4-1:0]    bcd;
  logic                      char_ok;

  // Form the magnitude; the most negative value maps to 2^(DATA_WIDTH-1)
  assign neg = value_i[DATA_WIDTH-1];
  assign mag = neg ? (~value_i + DATA_WIDTH'(1)) : value_i;

  sitda_dabble #(
    .DataWidth (DATA_WIDTH),
    .NumDigits (NumDigits)
  ) u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .neg_i   (neg),
    .mag_i   (mag),
    .busy_o  (dab_busy),
    .ctl_o   (ctl),
    .bcd_o   (bcd)
  );

  sitda_emit #(
    .NumDigits (NumDigits)
  ) u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .bcd_i        (bcd),
    .busy_o       (emit_busy),
    .strobe_o     (strobe_o),
    .ascii_char_o (ascii_char_o),
    .last_o       (last_o)
  );

  assign busy = dab_busy;

  // Minus sign or a decimal digit
  assign char_ok = (ascii_char_o == sitda_pkg::CharMinus) ||
                   ((ascii_char_o >= sitda_pkg::CharZero) &&
                    (ascii_char_o <= sitda_pkg::CharNine));

  // Checks
  `SITDA_ASSERT(a_accept_sets_busy, (start && !busy) |=> busy, "busy not raised after accept")
  `SITDA_NEVER(a_load_while_emitting, ctl.load && emit_busy, "emitter loaded while busy")
  `SITDA_NEVER(a_last_without_strobe, last_o && !strobe_o, "last without strobe")
  `SITDA_ASSERT(a_char_range, strobe_o |-> char_ok, "character out of range")

endmodule

// File: verif/signed_int_to_decimal_ascii_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the signed integer to decimal ASCII text block
// Drives a table of directed values, then random values of every length and
// sign with random start gaps. Each character strobe is compared with a
// queue of expected characters, from the table's texts or a bench converter model.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_tb;

  localparam int DataWidth    = 32;
  localparam int NumRandom    = 140;
  localparam int IdleLimit    = 2000;
  localparam int DrainCycles  = DataWidth + 16;

  // One expected character of a number's text
  typedef struct {
    logic [5:0] code;
    logic       last;
  } text_char_t;

  // Directed row: an empty text means the converter model supplies the result
  typedef struct {
    logic signed [DataWidth-1:0] value;
    string                       text;
  } dir_row_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        start;
  logic                        busy;
  logic signed [DataWidth-1:0] value_i;
  logic                        strobe_o;
  logic [5:0]                  ascii_char_o;
  logic                        last_o;

  text_char_t char_q[$];
  int         error_count = 0;
  int         idle_cycles = 0;

  dir_row_t dir_rows [20] = '{
    '{32'sd0,           "0"},
    '{32'sd1,           "1"},
    '{-32'sd1,          "-1"},
    '{32'sd9,           "9"},
    '{32'sd10,          "10"},
    '{-32'sd10,         "-10"},
    '{32'sh7FFF_FFFF,   "2147483647"},
    '{32'sh8000_0000,   "-2147483648"},
    '{32'sh8000_0001,   "-2147483647"},
    '{32'sd1000000000,  "1000000000"},
    '{-32'sd1000000000, "-1000000000"},
    '{-32'sd9,          ""},
    '{32'sd99,          ""},
    '{32'sd100,         ""},
    '{32'sd999999999,   ""},
    '{32'sd123456789,   ""},
    '{32'sh5555_5555,   ""},
    '{32'shAAAA_AAAA,   ""},
    '{32'sh0000_FFFF,   ""},
    '{32'shFFFF_0000,   ""}
  };

  signed_int_to_decimal_ascii #(
    .DATA_WIDTH(DataWidth)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .value_i     (value_i),
    .strobe_o    (strobe_o),
    .ascii_char_o(ascii_char_o),
    .last_o      (last_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Build the decimal text of one value: sign, then digits top first
  function automatic void predict_decimal_text(input logic signed [DataWidth-1:0] v);
    logic [DataWidth:0] mag;
    logic [3:0]         digit [10];
    int                 nd;
    text_char_t         c;
    // Form the magnitude one bit wider so the most negative value fits
    mag = v[DataWidth-1] ? (~{1'b1, v} + 1'b1) : {1'b0, v};
    nd = 0;
    if (mag == '0) begin
      digit[0] = 4'd0;
      nd = 1;
    end else begin
      while (mag != '0) begin
        digit[nd] = 4'(mag % 10);
        mag = mag / 10;
        nd++;
      end
    end
    if (v[DataWidth-1]) begin
      c.code = sitda_pkg::CharMinus;
      c.last = 1'b0;
      char_q.push_back(c);
    end
    for (int i = nd - 1; i >= 0; i--) begin
      c.code = sitda_pkg::CharZero + 6'(digit[i]);
      c.last = (i == 0);
      char_q.push_back(c);
    end
  endfunction

  // Queue a literal text as expected characters
  function automatic void push_typed_text(input string s);
    text_char_t c;
    for (int i = 0; i < s.len(); i++) begin
      c.code = 6'(s[i]);
      c.last = (i == s.len() - 1);
      char_q.push_back(c);
    end
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // Random value: full range, a chosen digit count, near the extremes, or tiny
  function automatic logic signed [DataWidth-1:0] pick_value();
    logic signed [DataWidth-1:0] v;
    int unsigned                 lim;
    int                          k;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: begin
        k = $urandom_range(1, 9);
        lim = 1;
        repeat (k) lim = lim * 10;
        v = $urandom_range(0, lim - 1);
        if ($urandom_range(0, 1)) v = -v;
      end
      2: begin
        if ($urandom_range(0, 1)) v = 32'sh8000_0000 + $urandom_range(0, 20);
        else v = 32'sh7FFF_FFFF - $urandom_range(0, 20);
      end
      default: v = $signed($urandom_range(0, 40)) - 20;
    endcase
    return v;
  endfunction

  // Hold start high until the transaction is taken, then queue its text
  task automatic send_value(input logic signed [DataWidth-1:0] v, input string text);
    value_i <= v;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (text.len() == 0) predict_decimal_text(v);
    else push_typed_text(text);
  endtask

  // Drop start for a number of cycles, with junk on the value bus
  task automatic idle_sender(input int cycles);
    repeat (cycles) begin
      start <= 1'b0;
      value_i <= $urandom;
      @(posedge clk_i);
    end
  endtask

  // Hold off until every queued character has come out
  task automatic wait_text_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (char_q.size() != 0) @(posedge clk_i);
  endtask

  // Compare each character strobe with the oldest expectation; run the watchdog
  always @(posedge clk_i) begin
    text_char_t exp_c;
    if (rst_ni) begin
      if (strobe_o) begin
        if (char_q.size() == 0) begin
          $display("%0t: unexpected character: expected none, actual char %0d last %0b",
                   $time, ascii_char_o, last_o);
          error_count++;
        end else begin
          exp_c = char_q.pop_front();
          if (ascii_char_o !== exp_c.code) begin
            $display("%0t: ascii_char mismatch: expected %0d, actual %0d",
                     $time, exp_c.code, ascii_char_o);
            error_count++;
          end
          if (last_o !== exp_c.last) begin
            $display("%0t: last mismatch: expected %0b, actual %0b",
                     $time, exp_c.last, last_o);
            error_count++;
          end
        end
      end
      if ((start && !busy) || strobe_o) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: watchdog expired with %0d characters outstanding",
                 $time, char_q.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    bit no_idle;
    rst_ni = 1'b0;
    start = 1'b0;
    value_i = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    foreach (dir_rows[i]) begin
      idle_sender(pick_gap());
      send_value(dir_rows[i].value, dir_rows[i].text);
    end
    wait_text_drained();

    // Random values, in groups that either idle or run back to back
    no_idle = 1'b0;
    for (int n = 0; n < NumRandom; n++) begin
      if (n % 16 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (n == NumRandom / 2) wait_text_drained();
      if (!no_idle) idle_sender(pick_gap());
      send_value(pick_value(), "");
    end

    wait_text_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (char_q.size() != 0) begin
      $display("%0t: %0d expected characters never arrived", $time, char_q.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
